/* src/atce_pkg.sv */
// ----------------------------------------------------------------------------
// ANSI terminal command encoder package
// Shared constants, byte codes, command kinds, state types and word structs.
// ----------------------------------------------------------------------------
package atce_pkg;

    // Sizes of the number path and the decimal converter.
    localparam int NUM_W          = 32;
    localparam int BCD_DIGITS     = 10;
    localparam int BCD_W          = 4 * BCD_DIGITS;
    localparam int COL_DIGITS     = 4;
    localparam int COL_BCD_W      = 4 * COL_DIGITS;
    localparam int BITS_PER_STEP  = 4;
    localparam int CONV_STEPS     = NUM_W / BITS_PER_STEP;
    localparam int DIG_CNT_W      = $clog2(BCD_DIGITS + 1);
    localparam int COL_CNT_W      = $clog2(COL_DIGITS + 1);
    localparam int DIG_IDX_W      = $clog2(BCD_DIGITS);
    localparam int COL_IDX_W      = $clog2(COL_DIGITS);

    // Output length limits.
    localparam int RESULT_LIMIT     = 64;
    localparam int MAX_LINE_RUN_DEF = 55;
    localparam int CURSOR_FIXED     = 4;
    localparam int COPY_W           = 6;
    localparam int ROOM_W           = 7;
    localparam int RUN_W            = 11;

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Command opcodes.
    localparam logic [2:0] OP_CURSOR     = 3'd0;
    localparam logic [2:0] OP_CLEAR      = 3'd1;
    localparam logic [2:0] OP_HLINE      = 3'd2;
    localparam logic [2:0] OP_ERASE_LINE = 3'd3;
    localparam logic [2:0] OP_ERASE_END  = 3'd4;
    localparam logic [2:0] OP_NUMBER     = 3'd5;

    // Byte codes of the escape sequences.
    localparam logic [7:0] CH_ESC      = 8'd27;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_H        = 8'h48;
    localparam logic [7:0] CH_TWO      = 8'h32;
    localparam logic [7:0] CH_J        = 8'h4A;
    localparam logic [7:0] CH_K        = 8'h4B;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_ZERO     = 8'h30;

    // Classified command kinds carried through the queue.
    typedef enum logic [2:0] {
        K_CURSOR,
        K_CLEAR,
        K_HLINE,
        K_ERASE_LINE,
        K_ERASE_END,
        K_NUMBER
    } cmd_kind_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CONV,
        F_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_ESC,
        B_LBRACKET,
        B_SIGN,
        B_DIG_A,
        B_SEMI,
        B_DIG_B,
        B_CMD_H,
        B_PATTERN,
        B_TWO,
        B_LETTER
    } back_state_t;

    // Input word.
    typedef struct packed {
        logic [2:0]        opcode;
        logic [9:0]        row;
        logic [9:0]        column;
        logic [9:0]        end_column;
        logic [7:0]        pattern;
        logic signed [31:0] number;
    } cmd_t;

    // Output word.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } result_t;

    // Classified command held in the queue.
    typedef struct packed {
        cmd_kind_t              kind;
        logic                   neg;
        logic [BCD_W-1:0]       digits_a;
        logic [DIG_CNT_W-1:0]   ndig_a;
        logic [COL_BCD_W-1:0]   digits_b;
        logic [COL_CNT_W-1:0]   ndig_b;
        logic [7:0]             pattern;
        logic [COPY_W-1:0]      copies;
    } entry_t;

endpackage

/* src/ansi_terminal_command_encoder_top.sv */
// Fixed sequences skip the decimal converters; cursor, line and number commands first
// pass through them, four bits at a time.
// Throughput: one output word per cycle while commands are queued; the front's work
// on later commands overlaps with output.
// Reset clears the front, queue and sequencer at once; no words leave until a start.
// ----------------------------------------------------------------------------
// ANSI terminal command encoder
// Front end, two-entry queue and byte sequencer producing escape sequences.
// ----------------------------------------------------------------------------
module ansi_terminal_command_encoder_top #(
    parameter int MAX_LINE_RUN = atce_pkg::MAX_LINE_RUN_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  atce_pkg::cmd_t    cmd,
    output logic              strobe,
    output atce_pkg::result_t result
);

    logic             push;
    logic             full;
    logic             pop;
    logic             empty;
    atce_pkg::entry_t push_data;
    atce_pkg::entry_t head;

    // Command front end.
    atce_front #(
        .MAX_LINE_RUN (MAX_LINE_RUN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    // Queue between the two halves.
    atce_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    // Byte sequencer.
    atce_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .empty  (empty),
        .pop    (pop),
        .strobe (strobe),
        .result (result)
    );

endmodule

/* src/atce_bcd_conv.sv */
// ----------------------------------------------------------------------------
// Binary to decimal converter
// Shift-and-add-3 conversion, four input bits per cycle.
// ----------------------------------------------------------------------------
module atce_bcd_conv #(
    parameter int DIGITS = atce_pkg::BCD_DIGITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic [atce_pkg::NUM_W-1:0]  value,
    output logic                        busy,
    output logic [4*DIGITS-1:0]         bcd
);

    localparam int DW     = 4 * DIGITS;
    localparam int STEP_W = $clog2(atce_pkg::CONV_STEPS);

    logic [atce_pkg::NUM_W-1:0] shift_reg, shift_next;
    logic [DW-1:0]              bcd_reg, bcd_next;
    logic [STEP_W-1:0]          step_reg, step_next;
    logic                       run_reg, run_next;

    // One conversion step: correct each digit, then shift in one bit.
    function automatic logic [DW-1:0] dd_bit(input logic [DW-1:0] b, input logic in_bit);
        logic [DW-1:0] adj;
        adj = b;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (b[4*i +: 4] >= 4'd5)
            begin
                adj[4*i +: 4] = b[4*i +: 4] + 4'd3;
            end
        end
        return {adj[DW-2:0], in_bit};
    endfunction

    // Next values of the converter registers.
    always_comb
    begin
        logic [DW-1:0] acc;
        acc        = bcd_reg;
        shift_next = shift_reg;
        bcd_next   = bcd_reg;
        step_next  = step_reg;
        run_next   = run_reg;
        if (load)
        begin
            shift_next = value;
            bcd_next   = '0;
            step_next  = '0;
            run_next   = 1'b1;
        end
        else if (run_reg)
        begin
            for (int j = 0; j < atce_pkg::BITS_PER_STEP; j++)
            begin
                acc = dd_bit(acc, shift_reg[atce_pkg::NUM_W-1-j]);
            end
            bcd_next   = acc;
            shift_next = shift_reg << atce_pkg::BITS_PER_STEP;
            step_next  = step_reg + 1'b1;
            if (step_reg == STEP_W'(atce_pkg::CONV_STEPS - 1))
            begin
                run_next = 1'b0;
            end
        end
    end

    // Control registers are reset; the data path is not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        bcd_reg   <= bcd_next;
    end

    assign busy = run_reg;
    assign bcd  = bcd_reg;

endmodule

/* src/atce_front.sv */
// ----------------------------------------------------------------------------
// Command front end
// Accepts commands, converts numbers to decimal and pushes classified entries.
// ----------------------------------------------------------------------------
module atce_front #(
    parameter int MAX_LINE_RUN = atce_pkg::MAX_LINE_RUN_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  atce_pkg::cmd_t   cmd,
    output logic             busy,
    output logic             push,
    output atce_pkg::entry_t push_data,
    input  logic             full
);

    atce_pkg::front_state_t state_reg, state_next;
    atce_pkg::cmd_kind_t    kind_reg, kind_next;
    logic                   neg_reg, neg_next;
    logic [7:0]             pattern_reg, pattern_next;
    logic [9:0]             col_reg, col_next;
    logic [9:0]             endc_reg, endc_next;

    logic                                     accept;
    logic                                     conv_load;
    logic [atce_pkg::NUM_W-1:0]               num_u;
    logic [atce_pkg::NUM_W-1:0]               mag;
    logic [atce_pkg::NUM_W-1:0]               conv_a_value;
    logic                                     conv_a_busy, conv_b_busy;
    logic [atce_pkg::BCD_W-1:0]               bcd_a;
    logic [atce_pkg::COL_BCD_W-1:0]           bcd_b;
    logic [atce_pkg::DIG_CNT_W-1:0]           ndig_a;
    logic [atce_pkg::COL_CNT_W-1:0]           ndig_b;
    logic [atce_pkg::RUN_W-1:0]               run_len;
    logic [atce_pkg::COPY_W-1:0]              run_cap;
    logic [atce_pkg::ROOM_W-1:0]              room;
    logic [atce_pkg::COPY_W-1:0]              copies;

    // Count of significant decimal digits, at least one.
    function automatic logic [atce_pkg::DIG_CNT_W-1:0] count_a(
        input logic [atce_pkg::BCD_W-1:0] b);
        logic [atce_pkg::DIG_CNT_W-1:0] n;
        n = atce_pkg::DIG_CNT_W'(1);
        for (int i = 1; i < atce_pkg::BCD_DIGITS; i++)
        begin
            if (b[4*i +: 4] != 4'd0)
            begin
                n = atce_pkg::DIG_CNT_W'(i + 1);
            end
        end
        return n;
    endfunction

    function automatic logic [atce_pkg::COL_CNT_W-1:0] count_b(
        input logic [atce_pkg::COL_BCD_W-1:0] b);
        logic [atce_pkg::COL_CNT_W-1:0] n;
        n = atce_pkg::COL_CNT_W'(1);
        for (int i = 1; i < atce_pkg::COL_DIGITS; i++)
        begin
            if (b[4*i +: 4] != 4'd0)
            begin
                n = atce_pkg::COL_CNT_W'(i + 1);
            end
        end
        return n;
    endfunction

    assign accept = start && (state_reg == atce_pkg::F_IDLE);
    assign busy   = (state_reg != atce_pkg::F_IDLE);

    // Magnitude of the signed number; the most negative value maps to 2^31.
    assign num_u        = cmd.number;
    assign mag          = num_u[atce_pkg::NUM_W-1] ? (~num_u + 1'b1) : num_u;
    assign conv_a_value = (cmd.opcode == atce_pkg::OP_NUMBER) ? mag
                                                             : atce_pkg::NUM_W'(cmd.row);

    // Row or number converter and column converter run in lockstep.
    atce_bcd_conv #(
        .DIGITS (atce_pkg::BCD_DIGITS)
    ) u_conv_a (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (conv_load),
        .value (conv_a_value),
        .busy  (conv_a_busy),
        .bcd   (bcd_a)
    );

    atce_bcd_conv #(
        .DIGITS (atce_pkg::COL_DIGITS)
    ) u_conv_b (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (conv_load),
        .value (atce_pkg::NUM_W'(cmd.column)),
        .busy  (conv_b_busy),
        .bcd   (bcd_b)
    );

    // Line length, clamped to the run limit and to the room left in the word budget.
    always_comb
    begin
        ndig_a = count_a(bcd_a);
        ndig_b = count_b(bcd_b);
        if (endc_reg >= col_reg)
        begin
            run_len = atce_pkg::RUN_W'(endc_reg) - atce_pkg::RUN_W'(col_reg) + 1'b1;
        end
        else
        begin
            run_len = '0;
        end
        if (run_len > atce_pkg::RUN_W'(MAX_LINE_RUN))
        begin
            run_cap = atce_pkg::COPY_W'(MAX_LINE_RUN);
        end
        else
        begin
            run_cap = run_len[atce_pkg::COPY_W-1:0];
        end
        room = atce_pkg::ROOM_W'(atce_pkg::RESULT_LIMIT - atce_pkg::CURSOR_FIXED)
             - atce_pkg::ROOM_W'(ndig_a) - atce_pkg::ROOM_W'(ndig_b);
        if (kind_reg != atce_pkg::K_HLINE)
        begin
            copies = '0;
        end
        else if (atce_pkg::ROOM_W'(run_cap) > room)
        begin
            copies = room[atce_pkg::COPY_W-1:0];
        end
        else
        begin
            copies = run_cap;
        end
    end

    // Entry pushed into the queue.
    always_comb
    begin
        push_data.kind     = kind_reg;
        push_data.neg      = neg_reg;
        push_data.digits_a = bcd_a;
        push_data.ndig_a   = ndig_a;
        push_data.digits_b = bcd_b;
        push_data.ndig_b   = ndig_b;
        push_data.pattern  = pattern_reg;
        push_data.copies   = copies;
    end

    // Front state machine: classify, convert, push.
    always_comb
    begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        neg_next     = neg_reg;
        pattern_next = pattern_reg;
        col_next     = col_reg;
        endc_next    = endc_reg;
        conv_load    = 1'b0;
        push         = 1'b0;
        unique case (state_reg)
            atce_pkg::F_IDLE:
            begin
                if (accept)
                begin
                    neg_next     = cmd.number[atce_pkg::NUM_W-1];
                    pattern_next = cmd.pattern;
                    col_next     = cmd.column;
                    endc_next    = cmd.end_column;
                    unique case (cmd.opcode)
                        atce_pkg::OP_CURSOR:
                        begin
                            kind_next  = atce_pkg::K_CURSOR;
                            conv_load  = 1'b1;
                            state_next = atce_pkg::F_CONV;
                        end
                        atce_pkg::OP_HLINE:
                        begin
                            kind_next  = atce_pkg::K_HLINE;
                            conv_load  = 1'b1;
                            state_next = atce_pkg::F_CONV;
                        end
                        atce_pkg::OP_NUMBER:
                        begin
                            kind_next  = atce_pkg::K_NUMBER;
                            conv_load  = 1'b1;
                            state_next = atce_pkg::F_CONV;
                        end
                        atce_pkg::OP_CLEAR:
                        begin
                            kind_next  = atce_pkg::K_CLEAR;
                            state_next = atce_pkg::F_PUSH;
                        end
                        atce_pkg::OP_ERASE_LINE:
                        begin
                            kind_next  = atce_pkg::K_ERASE_LINE;
                            state_next = atce_pkg::F_PUSH;
                        end
                        atce_pkg::OP_ERASE_END:
                        begin
                            kind_next  = atce_pkg::K_ERASE_END;
                            state_next = atce_pkg::F_PUSH;
                        end
                        default:
                        begin
                            // Unused opcodes produce no output and are dropped here.
                            state_next = atce_pkg::F_IDLE;
                        end
                    endcase
                end
            end
            atce_pkg::F_CONV:
            begin
                if (!conv_a_busy && !conv_b_busy)
                begin
                    state_next = atce_pkg::F_PUSH;
                end
            end
            atce_pkg::F_PUSH:
            begin
                if (!full)
                begin
                    push       = 1'b1;
                    state_next = atce_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = atce_pkg::F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= atce_pkg::F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        neg_reg     <= neg_next;
        pattern_reg <= pattern_next;
        col_reg     <= col_next;
        endc_reg    <= endc_next;
    end

endmodule

/* src/atce_queue.sv */
// ----------------------------------------------------------------------------
// Command queue
// Short first-in first-out buffer of classified commands between front and back.
// ----------------------------------------------------------------------------
module atce_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  atce_pkg::entry_t push_data,
    output logic             full,
    input  logic             pop,
    output atce_pkg::entry_t head,
    output logic             empty
);

    localparam int DEPTH = atce_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    atce_pkg::entry_t  slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* src/atce_back.sv */
// ----------------------------------------------------------------------------
// Byte sequencer
// Walks one classified command at a time and emits its bytes in order.
// ----------------------------------------------------------------------------
module atce_back (
    input  logic                clk,
    input  logic                rst_n,
    input  atce_pkg::entry_t    head,
    input  logic                empty,
    output logic                pop,
    output logic                strobe,
    output atce_pkg::result_t   result
);

    atce_pkg::back_state_t       state_reg, state_next;
    logic [atce_pkg::COPY_W-1:0] cnt_reg, cnt_next;
    atce_pkg::entry_t            cur_reg, cur_next;
    logic                        strobe_reg;
    atce_pkg::result_t           result_reg;

    logic       emit;
    logic [7:0] emit_byte;
    logic       emit_last;
    logic       advance;
    logic [3:0] digit_a;
    logic [3:0] digit_b;

    // Digit selected by the down counter, most significant first.
    assign digit_a = cur_reg.digits_a[{cnt_reg[atce_pkg::DIG_IDX_W-1:0], 2'b00} +: 4];
    assign digit_b = cur_reg.digits_b[{cnt_reg[atce_pkg::COL_IDX_W-1:0], 2'b00} +: 4];

    // Sequencer: one byte per cycle while a command is in hand, next command loaded on the final byte.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cur_next   = cur_reg;
        pop        = 1'b0;
        emit       = 1'b0;
        emit_byte  = atce_pkg::CH_ESC;
        emit_last  = 1'b0;
        advance    = 1'b0;
        unique case (state_reg)
            atce_pkg::B_IDLE:
            begin
                advance = 1'b1;
            end
            atce_pkg::B_ESC:
            begin
                emit       = 1'b1;
                emit_byte  = atce_pkg::CH_ESC;
                state_next = atce_pkg::B_LBRACKET;
            end
            atce_pkg::B_LBRACKET:
            begin
                emit      = 1'b1;
                emit_byte = atce_pkg::CH_LBRACKET;
                cnt_next  = atce_pkg::COPY_W'(cur_reg.ndig_a) - 1'b1;
                case (cur_reg.kind)
                    atce_pkg::K_CURSOR, atce_pkg::K_HLINE: state_next = atce_pkg::B_DIG_A;
                    atce_pkg::K_CLEAR:                     state_next = atce_pkg::B_TWO;
                    default:                               state_next = atce_pkg::B_LETTER;
                endcase
            end
            atce_pkg::B_SIGN:
            begin
                emit       = 1'b1;
                emit_byte  = atce_pkg::CH_MINUS;
                cnt_next   = atce_pkg::COPY_W'(cur_reg.ndig_a) - 1'b1;
                state_next = atce_pkg::B_DIG_A;
            end
            atce_pkg::B_DIG_A:
            begin
                emit      = 1'b1;
                emit_byte = atce_pkg::CH_ZERO + 8'(digit_a);
                if (cnt_reg == '0)
                begin
                    if (cur_reg.kind == atce_pkg::K_NUMBER)
                    begin
                        emit_last = 1'b1;
                        advance   = 1'b1;
                    end
                    else
                    begin
                        state_next = atce_pkg::B_SEMI;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            atce_pkg::B_SEMI:
            begin
                emit       = 1'b1;
                emit_byte  = atce_pkg::CH_SEMI;
                cnt_next   = atce_pkg::COPY_W'(cur_reg.ndig_b) - 1'b1;
                state_next = atce_pkg::B_DIG_B;
            end
            atce_pkg::B_DIG_B:
            begin
                emit      = 1'b1;
                emit_byte = atce_pkg::CH_ZERO + 8'(digit_b);
                if (cnt_reg == '0)
                begin
                    state_next = atce_pkg::B_CMD_H;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            atce_pkg::B_CMD_H:
            begin
                emit      = 1'b1;
                emit_byte = atce_pkg::CH_H;
                if (cur_reg.kind == atce_pkg::K_HLINE && cur_reg.copies != '0)
                begin
                    cnt_next   = cur_reg.copies;
                    state_next = atce_pkg::B_PATTERN;
                end
                else
                begin
                    emit_last = 1'b1;
                    advance   = 1'b1;
                end
            end
            atce_pkg::B_PATTERN:
            begin
                emit      = 1'b1;
                emit_byte = cur_reg.pattern;
                if (cnt_reg == atce_pkg::COPY_W'(1))
                begin
                    emit_last = 1'b1;
                    advance   = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            atce_pkg::B_TWO:
            begin
                emit       = 1'b1;
                emit_byte  = atce_pkg::CH_TWO;
                state_next = atce_pkg::B_LETTER;
            end
            atce_pkg::B_LETTER:
            begin
                emit      = 1'b1;
                emit_byte = (cur_reg.kind == atce_pkg::K_ERASE_LINE) ? atce_pkg::CH_K
                                                                      : atce_pkg::CH_J;
                emit_last = 1'b1;
                advance   = 1'b1;
            end
            default:
            begin
                state_next = atce_pkg::B_IDLE;
            end
        endcase

        // Take the next command from the queue, or go idle.
        if (advance)
        begin
            if (!empty)
            begin
                pop      = 1'b1;
                cur_next = head;
                cnt_next = atce_pkg::COPY_W'(head.ndig_a) - 1'b1;
                if (head.kind != atce_pkg::K_NUMBER)
                begin
                    state_next = atce_pkg::B_ESC;
                end
                else if (head.neg)
                begin
                    state_next = atce_pkg::B_SIGN;
                end
                else
                begin
                    state_next = atce_pkg::B_DIG_A;
                end
            end
            else
            begin
                state_next = atce_pkg::B_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= atce_pkg::B_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg             <= cnt_next;
        cur_reg             <= cur_next;
        result_reg.out_byte <= emit_byte;
        result_reg.last     <= emit_last;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

/* src/atce_checker.sv */
// ----------------------------------------------------------------------------
// Encoder port checker
// Assertions on the top-level ports, bound to every encoder instance.
// ----------------------------------------------------------------------------
module atce_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input atce_pkg::cmd_t    cmd,
    input logic              strobe,
    input atce_pkg::result_t result
);

    // A valid command keeps the front busy on the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.opcode <= atce_pkg::OP_NUMBER) |=> busy)
        else $error("front not busy after accepting a command");

    // The words of one command leave on consecutive cycles.
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !result.last) |=> strobe)
        else $error("gap inside a command's output");

    // A command opens with escape, a minus sign or a decimal digit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !$past(strobe && !result.last)) |->
            (result.out_byte == atce_pkg::CH_ESC || result.out_byte == atce_pkg::CH_MINUS
             || (result.out_byte >= atce_pkg::CH_ZERO
                 && result.out_byte <= atce_pkg::CH_ZERO + 8'd9)))
        else $error("command starts with an unexpected word");

endmodule

bind ansi_terminal_command_encoder_top atce_checker u_atce_checker (.*);
